// ===== sv/dacs_pkg.sv =====
// ----------------------------------------------------------------------------
// dacs_pkg - shared types for the double-array Aho-Corasick scanner
// Command codes, sequencer states, table record and match item layouts.
// ----------------------------------------------------------------------------
package dacs_pkg;

	typedef enum logic [2:0] {
		CMD_SCAN    = 3'd0,
		CMD_NEXT    = 3'd1,
		CMD_STATE   = 3'd2,
		CMD_SLOT    = 3'd3,
		CMD_LEN     = 3'd4,
		CMD_RESTART = 3'd5
	} cmd_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_REC,
		SQ_IDX,
		SQ_NXT,
		SQ_CHK,
		SQ_LST,
		SQ_LEN,
		SQ_OUT,
		SQ_DONE
	} seq_state_t;

	// one state record; count is wide enough for the largest list size
	typedef struct packed {
		logic signed [9:0] base;
		logic [8:0]        row;
		logic signed [8:0] parent;
		logic [7:0]        fail;
		logic [6:0]        count;
	} rec_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [8:0]        addr;
		logic signed [8:0] next_value;
		logic signed [9:0] base_value;
		logic [8:0]        row_pos;
		logic signed [8:0] parent_state;
		logic [7:0]        fail_state;
		logic [3:0]        out_count;
		logic [2:0]        out_slot;
		logic [7:0]        pattern_num;
		logic [7:0]        pattern_len;
	} wr_req_t;

	typedef struct packed {
		logic [7:0]  pattern;
		logic [15:0] start_pos;
		logic [15:0] end_pos;
		logic        last;
	} match_t;

endpackage

// ===== sv/double_array_aho_corasick_scan_top.sv =====
// ----------------------------------------------------------------------------
// double_array_aho_corasick_scan_top - Aho-Corasick text scanner
// Double-array trie automaton loaded by the host, scanned one byte per item.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (scan_valid / scan_stall): one command item. cmd selects a
//   byte to scan, a write into the next table, a state record, an output
//   slot or a pattern length, or a text restart (root, position zero).
//   Output channel (match_valid / match_stall): one item per pattern
//   reported by the state reached, last set on the final one for a byte.
//   Writes and restart complete when accepted. A scan byte reads the
//   current record, forms the index, reads the next entry and checks the
//   target's parent, retrying from the fail link on a miss at index,
//   entry or parent check; each reported match reads its list slot and
//   pattern length and waits while the receiver stalls. A final miss at
//   the root ends the byte. One record read port serves lookup and check.
//   One item is worked at a time; scan_stall is high meanwhile.
//   After reset a clearing sweep over max(NEXT_DEPTH, NUM_STATES) entries
//   empties the next table and state records; scan_stall stays high.
//   A stalled match item is held in the output register and the sequencer
//   waits for it to be taken before sending the next.
// ----------------------------------------------------------------------------
module double_array_aho_corasick_scan_top import dacs_pkg::*; #(
	parameter int NUM_STATES = 256,
	parameter int NEXT_DEPTH = 512,
	parameter int MAX_OUT    = 8,
	parameter int POS_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              scan_valid,
	output logic              scan_stall,
	input  logic [2:0]        cmd,
	input  logic [7:0]        text_char,
	input  logic [8:0]        addr,
	input  logic signed [8:0] next_value,
	input  logic signed [9:0] base_value,
	input  logic [8:0]        row_pos,
	input  logic signed [8:0] parent_state,
	input  logic [7:0]        fail_state,
	input  logic [3:0]        out_count,
	input  logic [2:0]        out_slot,
	input  logic [7:0]        pattern_num,
	input  logic [7:0]        pattern_len,
	output logic              match_valid,
	input  logic              match_stall,
	output logic [7:0]        match_pattern,
	output logic [15:0]       start_pos,
	output logic [15:0]       end_pos,
	output logic              last
);

	localparam int SW  = $clog2(NUM_STATES);
	localparam int NAW = $clog2(NEXT_DEPTH);
	localparam int LAW = $clog2(NUM_STATES * MAX_OUT);

	logic           accept, seq_idle, clr_busy, out_free, emit;
	wr_req_t        wr_req;
	rec_t           rec_rd;
	logic [SW-1:0]  rec_raddr;
	logic [NAW-1:0] next_raddr;
	logic [LAW-1:0] list_raddr;
	logic [7:0]     len_raddr, list_rd, len_rd;
	logic [8:0]     next_rd;
	match_t         emit_data, out_q;
	logic           oval_q;

	// busy while sweeping the tables or working on an item
	assign scan_stall = !seq_idle || clr_busy;
	assign accept     = scan_valid && !scan_stall;

	always_comb begin
		wr_req.cmd          = cmd;
		wr_req.addr         = addr;
		wr_req.next_value   = next_value;
		wr_req.base_value   = base_value;
		wr_req.row_pos      = row_pos;
		wr_req.parent_state = parent_state;
		wr_req.fail_state   = fail_state;
		wr_req.out_count    = out_count;
		wr_req.out_slot     = out_slot;
		wr_req.pattern_num  = pattern_num;
		wr_req.pattern_len  = pattern_len;
	end

	dacs_tables #(
		.NUM_STATES(NUM_STATES),
		.NEXT_DEPTH(NEXT_DEPTH),
		.MAX_OUT   (MAX_OUT)
	) u_tables (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept),
		.wr_req    (wr_req),
		.rec_raddr (rec_raddr),
		.next_raddr(next_raddr),
		.list_raddr(list_raddr),
		.len_raddr (len_raddr),
		.rec_rd    (rec_rd),
		.next_rd   (next_rd),
		.list_rd   (list_rd),
		.len_rd    (len_rd),
		.clr_busy  (clr_busy)
	);

	dacs_seq #(
		.NUM_STATES(NUM_STATES),
		.NEXT_DEPTH(NEXT_DEPTH),
		.MAX_OUT   (MAX_OUT),
		.POS_BITS  (POS_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (accept && cmd == CMD_SCAN),
		.restart   (accept && cmd == CMD_RESTART),
		.ch        (text_char),
		.out_free  (out_free),
		.rec_rd    (rec_rd),
		.next_rd   (next_rd),
		.list_rd   (list_rd),
		.len_rd    (len_rd),
		.idle      (seq_idle),
		.rec_raddr (rec_raddr),
		.next_raddr(next_raddr),
		.list_raddr(list_raddr),
		.len_raddr (len_raddr),
		.emit      (emit),
		.emit_data (emit_data)
	);

	// output register: free when empty or being taken this cycle
	assign out_free = !oval_q || !match_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (emit) begin
			oval_q <= 1'b1;
		end else if (!match_stall) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= emit_data;
	end

	assign match_valid   = oval_q;
	assign match_pattern = out_q.pattern;
	assign start_pos     = out_q.start_pos;
	assign end_pos       = out_q.end_pos;
	assign last          = out_q.last;

endmodule

// ===== sv/dacs_tables.sv =====
// ----------------------------------------------------------------------------
// dacs_tables - automaton memories
// Next table, state records, output lists and pattern lengths; host writes,
// registered reads, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module dacs_tables import dacs_pkg::*; #(
	parameter int NUM_STATES = 256,
	parameter int NEXT_DEPTH = 512,
	parameter int MAX_OUT    = 8,
	localparam int SW  = $clog2(NUM_STATES),
	localparam int NAW = $clog2(NEXT_DEPTH),
	localparam int LAW = $clog2(NUM_STATES * MAX_OUT)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  wr_req_t        wr_req,
	input  logic [SW-1:0]  rec_raddr,
	input  logic [NAW-1:0] next_raddr,
	input  logic [LAW-1:0] list_raddr,
	input  logic [7:0]     len_raddr,
	output rec_t           rec_rd,
	output logic [8:0]     next_rd,
	output logic [7:0]     list_rd,
	output logic [7:0]     len_rd,
	output logic           clr_busy
);

	localparam int CLR_N = (NEXT_DEPTH > NUM_STATES) ? NEXT_DEPTH : NUM_STATES;
	localparam int CLW   = $clog2(CLR_N + 1);

	logic [8:0] next_mem [NEXT_DEPTH];
	rec_t       rec_mem  [NUM_STATES];
	logic [7:0] list_mem [NUM_STATES * MAX_OUT];
	logic [7:0] len_mem  [256];

	logic [CLW-1:0] clr_q;
	rec_t           rec_wr;
	rec_t           rec_clr;
	logic [6:0]     cnt_sat;

	assign clr_busy = (32'(clr_q) != CLR_N);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		cnt_sat = (32'(wr_req.out_count) > MAX_OUT) ? 7'(MAX_OUT) : 7'(wr_req.out_count);
		rec_wr.base   = wr_req.base_value;
		rec_wr.row    = wr_req.row_pos;
		rec_wr.parent = wr_req.parent_state;
		rec_wr.fail   = wr_req.fail_state;
		rec_wr.count  = cnt_sat;
		rec_clr.base   = '1;
		rec_clr.row    = '0;
		rec_clr.parent = '1;
		rec_clr.fail   = '0;
		rec_clr.count  = '0;
	end

	// next table
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			if (32'(clr_q) < NEXT_DEPTH)
				next_mem[NAW'(clr_q)] <= '1;
		end else if (wr_en && wr_req.cmd == CMD_NEXT && 32'(wr_req.addr) < NEXT_DEPTH) begin
			next_mem[NAW'(wr_req.addr)] <= wr_req.next_value;
		end
		next_rd <= next_mem[next_raddr];
	end

	// state records
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			if (32'(clr_q) < NUM_STATES)
				rec_mem[SW'(clr_q)] <= rec_clr;
		end else if (wr_en && wr_req.cmd == CMD_STATE && 32'(wr_req.addr) < NUM_STATES) begin
			rec_mem[SW'(wr_req.addr)] <= rec_wr;
		end
		rec_rd <= rec_mem[rec_raddr];
	end

	// output lists, MAX_OUT slots per state
	always_ff @(posedge clk) begin
		if (wr_en && wr_req.cmd == CMD_SLOT && 32'(wr_req.addr) < NUM_STATES
				&& 32'(wr_req.out_slot) < MAX_OUT) begin
			list_mem[LAW'(32'(wr_req.addr) * MAX_OUT + 32'(wr_req.out_slot))] <= wr_req.pattern_num;
		end
		list_rd <= list_mem[list_raddr];
	end

	// pattern lengths
	always_ff @(posedge clk) begin
		if (wr_en && wr_req.cmd == CMD_LEN)
			len_mem[wr_req.pattern_num] <= wr_req.pattern_len;
		len_rd <= len_mem[len_raddr];
	end

endmodule

// ===== sv/dacs_seq.sv =====
// ----------------------------------------------------------------------------
// dacs_seq - scan sequencer
// Walks lookup, check and fail-link retries through one shared index adder,
// then steps through the output list of the state reached.
// ----------------------------------------------------------------------------
module dacs_seq import dacs_pkg::*; #(
	parameter int NUM_STATES = 256,
	parameter int NEXT_DEPTH = 512,
	parameter int MAX_OUT    = 8,
	parameter int POS_BITS   = 16,
	localparam int SW  = $clog2(NUM_STATES),
	localparam int NAW = $clog2(NEXT_DEPTH),
	localparam int LAW = $clog2(NUM_STATES * MAX_OUT),
	localparam int CW  = $clog2(MAX_OUT + 1),
	localparam int TW  = $clog2(NUM_STATES + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic           restart,
	input  logic [7:0]     ch,
	input  logic           out_free,
	input  rec_t           rec_rd,
	input  logic [8:0]     next_rd,
	input  logic [7:0]     list_rd,
	input  logic [7:0]     len_rd,
	output logic           idle,
	output logic [SW-1:0]  rec_raddr,
	output logic [NAW-1:0] next_raddr,
	output logic [LAW-1:0] list_raddr,
	output logic [7:0]     len_raddr,
	output logic           emit,
	output match_t         emit_data
);

	seq_state_t state_q, state_d;

	logic [SW-1:0]       cur_q, s_q, t_q, fail_q, fail_now;
	logic [7:0]          ch_q, pid_q;
	logic [TW-1:0]       tries_q;
	logic [CW-1:0]       cnt_q, k_q;
	logic [POS_BITS-1:0] pos_q, start_w;
	logic [11:0]         idx;
	logic                idx_ok, t_ok, par_ok, miss, give_up, is_last;

	always_comb begin
		// shared index adder: row + base + byte, bit 11 is the sign
		idx = {3'b0, rec_rd.row} + {{2{rec_rd.base[9]}}, rec_rd.base} + {4'b0, ch_q};
		idx_ok = !idx[11] && (32'(idx[10:0]) < NEXT_DEPTH);
		t_ok   = !next_rd[8] && (32'(next_rd[7:0]) < NUM_STATES);
		par_ok = !rec_rd.parent[8] && (32'(rec_rd.parent[7:0]) == 32'(s_q));
		if (state_q == SQ_IDX)
			fail_now = (32'(rec_rd.fail) < NUM_STATES) ? SW'(rec_rd.fail) : '0;
		else
			fail_now = fail_q;
		give_up = (s_q == '0) || (32'(tries_q) >= NUM_STATES);
		is_last = ({1'b0, k_q} + 1'b1) == {1'b0, cnt_q};
		start_w = pos_q - POS_BITS'(len_rd) + 1'b1;
		miss = 1'b0;
		case (state_q)
			SQ_IDX:  miss = !idx_ok;
			SQ_NXT:  miss = !t_ok;
			SQ_CHK:  miss = !par_ok;
			default: miss = 1'b0;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		idle       = 1'b0;
		rec_raddr  = s_q;
		next_raddr = NAW'(idx[10:0]);
		list_raddr = LAW'(32'(t_q) * MAX_OUT + 32'(k_q));
		len_raddr  = (state_q == SQ_LEN) ? list_rd : pid_q;
		emit       = 1'b0;
		emit_data.pattern   = pid_q;
		emit_data.start_pos = 16'(start_w);
		emit_data.end_pos   = 16'(pos_q);
		emit_data.last      = is_last;
		if (miss) begin
			state_d = give_up ? SQ_DONE : SQ_REC;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					idle      = 1'b1;
					rec_raddr = cur_q;
					if (go)
						state_d = SQ_IDX;
				end
				SQ_REC:  state_d = SQ_IDX;
				SQ_IDX:  state_d = SQ_NXT;
				SQ_NXT: begin
					rec_raddr = SW'(next_rd[7:0]);
					state_d   = SQ_CHK;
				end
				SQ_CHK:  state_d = (rec_rd.count == '0) ? SQ_DONE : SQ_LST;
				SQ_LST:  state_d = SQ_LEN;
				SQ_LEN:  state_d = SQ_OUT;
				SQ_OUT: begin
					if (out_free) begin
						emit    = 1'b1;
						state_d = is_last ? SQ_DONE : SQ_LST;
					end
				end
				SQ_DONE: state_d = SQ_IDLE;
				default: state_d = SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cur_q   <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_IDLE && restart) begin
				cur_q <= '0;
				pos_q <= '0;
			end
			if (miss && give_up)
				cur_q <= '0;
			if (state_q == SQ_CHK && !miss)
				cur_q <= t_q;
			if (state_q == SQ_DONE)
				pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_IDLE) begin
			s_q     <= cur_q;
			ch_q    <= ch;
			tries_q <= '0;
		end
		if (state_q == SQ_IDX)
			fail_q <= fail_now;
		if (miss) begin
			s_q     <= fail_now;
			tries_q <= tries_q + 1'b1;
		end
		if (state_q == SQ_NXT)
			t_q <= SW'(next_rd[7:0]);
		if (state_q == SQ_CHK) begin
			cnt_q <= CW'(rec_rd.count);
			k_q   <= '0;
		end
		if (state_q == SQ_LEN)
			pid_q <= list_rd;
		if (emit)
			k_q <= k_q + 1'b1;
	end

endmodule

// ===== tb/double_array_aho_corasick_scan_top_test.sv =====
// ----------------------------------------------------------------------------
// double_array_aho_corasick_scan_top_test - self-checking bench for the scanner
// Loads small trie automata over the command channel, scans text bytes and
// checks each match item against a local model of the lookup, fail-link walk
// and match listing. A directed table runs first, then random traffic under
// varying valid/stall pressure.
// ----------------------------------------------------------------------------
module double_array_aho_corasick_scan_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dacs_pkg::*;

	// codes the package leaves out; the block ignores them
	localparam logic [2:0] CMD_NOP6 = 3'd6;
	localparam logic [2:0] CMD_NOP7 = 3'd7;
	localparam int N_ST      = 256;
	localparam int N_NEXT    = 512;
	localparam int N_SLOT    = 8;
	localparam int N_TRIE    = 16;   // states used by the loaded automaton
	localparam int ALPHA_LO  = 97;   // scan alphabet 'a'..'d'
	localparam int DOG_LIMIT = 6000; // cycles without any handshake

	typedef struct {
		logic [2:0]        cmd;
		logic [7:0]        ch;
		logic [8:0]        addr;
		logic signed [8:0] nv;
		logic signed [9:0] bv;
		logic [8:0]        row;
		logic signed [8:0] par;
		logic [7:0]        fl;
		logic [3:0]        cnt;
		logic [2:0]        slot;
		logic [7:0]        pid;
		logic [7:0]        len;
	} item_t;

	// directed row: n_typed < 0 means the model decides the result
	typedef struct {
		item_t  it;
		int     n_typed;
		match_t m;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              scan_valid;
	logic              scan_stall;
	logic [2:0]        cmd;
	logic [7:0]        text_char;
	logic [8:0]        addr;
	logic signed [8:0] next_value;
	logic signed [9:0] base_value;
	logic [8:0]        row_pos;
	logic signed [8:0] parent_state;
	logic [7:0]        fail_state;
	logic [3:0]        out_count;
	logic [2:0]        out_slot;
	logic [7:0]        pattern_num;
	logic [7:0]        pattern_len;
	logic              match_valid;
	logic              match_stall;
	logic [7:0]        match_pattern;
	logic [15:0]       start_pos;
	logic [15:0]       end_pos;
	logic              last;

	double_array_aho_corasick_scan_top uut (.*);

	// local copy of the automaton tables
	logic signed [8:0] next_mem [N_NEXT];
	logic signed [9:0] base_mem [N_ST];
	logic [8:0]        row_mem [N_ST];
	logic signed [8:0] parent_mem [N_ST];
	logic [7:0]        fail_mem [N_ST];
	int                cnt_mem [N_ST];
	logic [7:0]        list_mem [N_ST*N_SLOT];
	logic [7:0]        len_mem [256];
	logic [7:0]        cur_state;
	logic [15:0]       text_pos;

	// which entries hold a written value: keeps stimulus off undefined reads
	bit st_ok [N_ST];
	bit slot_ok [N_ST][N_SLOT];
	bit len_ok [256];

	match_t pending_matches[$];
	row_t   dir_rows[$];
	int     tree_parent [N_TRIE];
	int     errors, n_scans, n_matches, idle_pct, stall_pct, quiet_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver pressure, redrawn every cycle
	always @(negedge clk)
		match_stall = ($urandom_range(0, 99) < stall_pct);

	// watchdog: any handshake restarts the count
	always @(posedge clk) begin
		if ((scan_valid && !scan_stall) || (match_valid && !match_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= DOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d matches outstanding", $realtime,
				pending_matches.size());
			$display("tb: failure");
			$finish;
		end
	end

	// match checker: oldest expectation against each accepted match item
	always @(posedge clk) begin
		match_t want;
		if (match_valid && !match_stall) begin
			n_matches++;
			if (pending_matches.size() == 0) begin
				errors++;
				$display("%0t: unexpected match pattern=%0d start=%0d end=%0d last=%0d",
					$realtime, match_pattern, start_pos, end_pos, last);
			end else begin
				want = pending_matches.pop_front();
				if (match_pattern !== want.pattern || start_pos !== want.start_pos ||
				    end_pos !== want.end_pos || last !== want.last) begin
					errors++;
					$display("%0t: match mismatch exp pat=%0d st=%0d end=%0d last=%0d",
						$realtime, want.pattern, want.start_pos, want.end_pos, want.last);
					$display("%0t:                act pat=%0d st=%0d end=%0d last=%0d",
						$realtime, match_pattern, start_pos, end_pos, last);
				end
			end
		end
	end

	// one trie step; -1 on a miss (bad index, empty entry, parent mismatch)
	function automatic int trie_move(int s, logic [7:0] c);
		int idx, t;
		idx = int'(row_mem[s]) + int'(base_mem[s]) + int'(c);
		if (idx < 0 || idx >= N_NEXT)
			return -1;
		t = int'(next_mem[idx]);
		if (t < 0 || t >= N_ST)
			return -1;
		if (int'(parent_mem[t]) != s)
			return -1;
		return t;
	endfunction

	// model one accepted item; returns the matches it should produce
	task automatic model_item(input item_t it, output match_t found[$]);
		int s, t, tries, pid;
		match_t m;
		found = {};
		case (it.cmd)
			CMD_SCAN: begin
				s = cur_state;
				tries = 0;
				forever begin
					t = trie_move(s, it.ch);
					if (t >= 0 || s == 0 || tries >= N_ST)
						break;
					tries++;
					s = fail_mem[s];
				end
				if (t >= 0) begin
					cur_state = 8'(t);
					for (int k = 0; k < cnt_mem[t]; k++) begin
						pid = list_mem[t*N_SLOT + k];
						m.pattern = 8'(pid);
						m.start_pos = text_pos - 16'(len_mem[pid]) + 16'd1;
						m.end_pos = text_pos;
						m.last = (k + 1 == cnt_mem[t]);
						found = {found, m};
					end
				end else
					cur_state = 0;
				text_pos++;
				n_scans++;
			end
			CMD_NEXT:
				next_mem[it.addr] = it.nv;
			CMD_STATE:
				if (it.addr < N_ST) begin
					base_mem[it.addr] = it.bv;
					row_mem[it.addr] = it.row;
					parent_mem[it.addr] = it.par;
					fail_mem[it.addr] = it.fl;
					cnt_mem[it.addr] = (it.cnt > N_SLOT) ? N_SLOT : it.cnt;
					st_ok[it.addr] = 1'b1;
				end
			CMD_SLOT:
				if (it.addr < N_ST) begin
					list_mem[it.addr*N_SLOT + it.slot] = it.pid;
					slot_ok[it.addr][it.slot] = 1'b1;
				end
			CMD_LEN: begin
				len_mem[it.pid] = it.len;
				len_ok[it.pid] = 1'b1;
			end
			CMD_RESTART: begin
				cur_state = 0;
				text_pos = 0;
			end
			default: ;
		endcase
	endtask

	// drive one item from a falling edge, hold until taken, return at a falling edge
	task automatic send_item(input item_t it, input int n_typed, input match_t typed);
		match_t found[$];
		while ($urandom_range(0, 99) < idle_pct) begin
			scan_valid = 1'b0;
			@(negedge clk);
		end
		cmd = it.cmd;
		text_char = it.ch;
		addr = it.addr;
		next_value = it.nv;
		base_value = it.bv;
		row_pos = it.row;
		parent_state = it.par;
		fail_state = it.fl;
		out_count = it.cnt;
		out_slot = it.slot;
		pattern_num = it.pid;
		pattern_len = it.len;
		scan_valid = 1'b1;
		do
			@(posedge clk);
		while (scan_stall);
		model_item(it, found);
		if (n_typed < 0)
			foreach (found[i])
				pending_matches = {pending_matches, found[i]};
		else if (n_typed == 1)
			pending_matches = {pending_matches, typed};
		@(negedge clk);
	endtask

	task automatic add_row(input item_t it, input int n_typed, input match_t m);
		row_t r;
		r.it = it;
		r.n_typed = n_typed;
		r.m = m;
		dir_rows = {dir_rows, r};
	endtask

	function automatic item_t noise_item();
		item_t it;
		it.cmd = 3'($urandom_range(0, 7));
		it.ch = 8'($urandom);
		it.addr = 9'($urandom);
		it.nv = 9'(int'($urandom_range(0, 256)) - 1);
		it.bv = 10'($urandom);
		it.row = 9'($urandom);
		it.par = 9'(int'($urandom_range(0, 256)) - 1);
		it.fl = 8'($urandom);
		it.cnt = 4'($urandom);
		it.slot = 3'($urandom);
		it.pid = 8'($urandom);
		it.len = 8'($urandom_range(1, 255));
		return it;
	endfunction

	function automatic item_t mk(logic [2:0] c, int a = 0, int v = 0);
		item_t it;
		it = noise_item();
		it.cmd = c;
		it.addr = 9'(a);
		it.ch = 8'(v);
		it.nv = 9'(v);
		return it;
	endfunction

	function automatic item_t mk_state(int a, int b, int r, int p, int f, int n);
		item_t it;
		it = mk(CMD_STATE, a);
		it.bv = 10'(b);
		it.row = 9'(r);
		it.par = 9'(p);
		it.fl = 8'(f);
		it.cnt = 4'(n);
		return it;
	endfunction

	function automatic item_t mk_slot(int a, int s, int p);
		item_t it;
		it = mk(CMD_SLOT, a);
		it.slot = 3'(s);
		it.pid = 8'(p);
		return it;
	endfunction

	function automatic item_t mk_len(int p, int l);
		item_t it;
		it = mk(CMD_LEN);
		it.pid = 8'(p);
		it.len = 8'(l);
		return it;
	endfunction

	// a state whose record is written, so its row and fail link are defined
	function automatic int pick_state();
		int s;
		repeat (20) begin
			s = ($urandom_range(0, 1) != 0) ? $urandom_range(0, N_TRIE - 1) :
				$urandom_range(0, N_ST - 1);
			if (st_ok[s])
				return s;
		end
		return 0;
	endfunction

	function automatic int pick_pid();
		int p;
		repeat (20) begin
			p = $urandom_range(0, 255);
			if (len_ok[p])
				return p;
		end
		return 0;
	endfunction

	// mixed traffic: mostly scans over the alphabet, writes kept safe
	function automatic item_t random_item();
		item_t it;
		int r, a, k;
		it = noise_item();
		r = $urandom_range(0, 99);
		a = ($urandom_range(0, 3) != 0) ? $urandom_range(0, N_TRIE - 1) : it.addr;
		if (r < 68) begin
			it.cmd = CMD_SCAN;
			if ($urandom_range(0, 9) != 0)
				it.ch = 8'($urandom_range(ALPHA_LO, ALPHA_LO + 3));
		end else if (r < 74)
			it.cmd = CMD_NEXT;
		else if (r < 82) begin
			it.cmd = CMD_STATE;
			it.addr = 9'(a);
			if (a < N_ST) begin
				it.fl = 8'(($urandom_range(0, 1) != 0) ? pick_state() : a);
				k = 0;
				while (k < N_SLOT && slot_ok[a][k])
					k++;
				it.cnt = 4'((k == N_SLOT) ? $urandom_range(0, 15) : $urandom_range(0, k));
				if (a < N_TRIE) begin
					// keep the trie shape so scans still walk it
					it.bv = 10'(-ALPHA_LO);
					it.row = 9'(32 + 4*a);
					it.par = 9'(tree_parent[a]);
				end
			end
		end else if (r < 90) begin
			it.cmd = CMD_SLOT;
			it.addr = 9'(a);
			it.pid = 8'(pick_pid());
		end else if (r < 95)
			it.cmd = CMD_LEN;
		else if (r < 97)
			it.cmd = CMD_RESTART;
		else
			it.cmd = $urandom_range(0, 1) ? CMD_NOP6 : CMD_NOP7;
		return it;
	endfunction

	// well-formed automaton over N_TRIE states and four symbols
	task automatic load_trie();
		bit used [N_TRIE][4];
		int p, j, k, n;
		match_t none;
		none = '0;
		for (int q = 0; q < N_TRIE; q++)
			send_item(mk_len(q, $urandom_range(1, 6)), -1, none);
		tree_parent[0] = -1;
		for (int t = 1; t < N_TRIE; t++) begin
			do begin
				p = $urandom_range(0, t - 1);
				j = $urandom_range(0, 3);
			end while (used[p][j]);
			used[p][j] = 1'b1;
			tree_parent[t] = p;
			send_item(mk(CMD_NEXT, 32 + 4*p + j, t), -1, none);
		end
		for (int s = 0; s < N_TRIE; s++) begin
			k = $urandom_range(0, N_SLOT);
			for (int i = 0; i < k; i++)
				send_item(mk_slot(s, i, $urandom_range(0, 9) ? $urandom_range(0, 15) : 255),
					-1, none);
			n = (k == N_SLOT) ? $urandom_range(0, 15) : $urandom_range(0, k);
			send_item(mk_state(s, -ALPHA_LO, 32 + 4*s, tree_parent[s],
				(s == 0) ? 0 : $urandom_range(0, s - 1), n), -1, none);
		end
	endtask

	task automatic drain(input int extra);
		while (pending_matches.size() != 0)
			@(negedge clk);
		repeat (extra)
			@(negedge clk);
	endtask

	initial begin
		match_t none, hit;
		int     phase_idle [4] = '{0, 46, 0, 28};
		int     phase_stall [4] = '{0, 0, 46, 28};

		errors = 0;
		n_scans = 0;
		n_matches = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		match_stall = 1'b0;
		scan_valid = 1'b0;
		{cmd, text_char, addr, next_value, base_value, row_pos} = '0;
		{parent_state, fail_state, out_count, out_slot, pattern_num, pattern_len} = '0;
		foreach (next_mem[i])
			next_mem[i] = -1;
		foreach (base_mem[i]) begin
			base_mem[i] = -1;
			parent_mem[i] = -1;
			cnt_mem[i] = 0;
			row_mem[i] = 0;
			fail_mem[i] = 0;
		end
		cur_state = 0;
		text_pos = 0;
		none = '0;

		arst_n = 1'b0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table; a pattern of full length reported at position zero
		// wraps its start back to 0xFF02
		hit = '{pattern: 8'd255, start_pos: 16'hFF02, end_pos: 16'd0, last: 1'b1};
		add_row(mk_state(0, 0, 0, -1, 0, 0), -1, none);
		add_row(mk(CMD_SCAN, 0, 0), 0, none);          // miss at root
		add_row(mk_len(255, 255), -1, none);
		add_row(mk_slot(1, 0, 255), -1, none);
		add_row(mk_state(1, 511, 0, 0, 0, 1), -1, none);
		add_row(mk(CMD_NEXT, 200, 1), -1, none);
		add_row(mk(CMD_RESTART), -1, none);
		add_row(mk(CMD_SCAN, 0, 200), 1, hit);
		add_row(mk(CMD_SCAN, 0, 0), 0, none);          // empty entry
		add_row(mk(CMD_NEXT, 511, 2), -1, none);
		add_row(mk(CMD_SCAN, 0, 200), -1, none);
		add_row(mk(CMD_SCAN, 0, 0), 0, none);          // parent mismatch
		add_row(mk(CMD_SCAN, 0, 200), -1, none);
		add_row(mk(CMD_SCAN, 0, 255), 0, none);        // index past table
		add_row(mk_state(3, -512, 511, 255, 0, 0), -1, none);
		add_row(mk_state(300, 511, 511, 255, 255, 15), -1, none); // ignored
		add_row(mk_slot(511, 7, 0), -1, none);         // ignored
		add_row(mk(CMD_NEXT, 511, -1), -1, none);
		add_row(mk(CMD_NOP6), -1, none);
		add_row(mk(CMD_NOP7), -1, none);
		add_row(mk(CMD_SCAN, 0, 200), -1, none);
		add_row(mk_state(1, 511, 0, 0, 1, 1), -1, none); // fail link to itself
		add_row(mk(CMD_SCAN, 0, 9), 0, none);          // fail cycle gives up
		add_row(mk_len(0, 1), -1, none);
		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].n_typed, dir_rows[i].m);
		scan_valid = 1'b0;
		drain(20);

		// automaton load, then random traffic across the pressure phases
		load_trie();
		send_item(mk(CMD_RESTART), -1, none);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			for (int i = 0; i < 20; i++)
				send_item(random_item(), -1, none);
			// hold the sender off until the block has nothing left to report
			scan_valid = 1'b0;
			drain(20);
		end
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < 15; i++)
			send_item(random_item(), -1, none);
		scan_valid = 1'b0;
		drain(1100);

		$display("covered %0d scanned bytes and %0d match items over directed, load and",
			n_scans, n_matches);
		$display("four pressure phases, with %0d mismatches", errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== double_array_aho_corasick_scan_top.f =====
sv/dacs_pkg.sv
sv/dacs_tables.sv
sv/dacs_seq.sv
sv/double_array_aho_corasick_scan_top.sv
tb/double_array_aho_corasick_scan_top_test.sv
